@@ src/arm_data_processing_alu_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the data-processing ALU
// Shared implication forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARM_DATA_PROCESSING_ALU_TOP_DEFINES_SVH
`define ARM_DATA_PROCESSING_ALU_TOP_DEFINES_SVH

// same-cycle implication
`define ADP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adp_alu assertion failed");

// next-cycle implication
`define ADP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adp_alu assertion failed");

`endif

@@ src/adp_alu_pkg.sv @@
// ----------------------------------------------------------------------------
// adp_alu_pkg
// Types and codes shared by the data-processing ALU files.
// ----------------------------------------------------------------------------
package adp_alu_pkg;

   typedef enum logic [3:0] {
      OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
      OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
      OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
      OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
   } op_type;

   localparam logic [1:0] FORM_ROT_IMM   = 2'd0;
   localparam logic [1:0] FORM_IMM_SHIFT = 2'd1;
   localparam logic [1:0] FORM_REG_SHIFT = 2'd2;

   localparam logic [1:0] KIND_LSL = 2'd0;
   localparam logic [1:0] KIND_LSR = 2'd1;
   localparam logic [1:0] KIND_ASR = 2'd2;
   localparam logic [1:0] KIND_ROR = 2'd3;

   localparam logic [7:0] SHIFT_WORD = 8'd32;

   typedef struct packed {
      logic [3:0]  op;
      logic        set_flags;
      logic [1:0]  operand_form;
      logic [31:0] first_operand;
      logic [31:0] second_operand;
      logic [7:0]  imm_byte;
      logic [3:0]  rotate_field;
      logic [1:0]  shift_kind;
      logic [7:0]  shift_count;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [31:0] alu_result;
      logic        write_enable;
      logic [3:0]  flags_out;
      logic        flags_written;
   } rsp_type;

   typedef struct packed {
      logic [31:0] operand;
      logic        carry;
   } shifter_out_type;

endpackage

@@ src/adp_alu_ifs.sv @@
// ----------------------------------------------------------------------------
// adp_alu channel interfaces
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface adp_alu_req_if;
   logic                 valid;
   logic                 ready;
   adp_alu_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface adp_alu_rsp_if;
   logic                 valid;
   logic                 ready;
   adp_alu_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/arm_data_processing_alu_top.sv @@
// ----------------------------------------------------------------------------
// arm_data_processing_alu_top
// ARM data-processing ALU with barrel shifter, one word per cycle while rsp_bus does not stall.
//
// req_bus carries one operation word (opcode, S bit, operand form, Rn, Rm,
// immediate fields, shift kind and count, current NZCV). rsp_bus returns one
// result word per request: result, Rd write enable, new NZCV, flag write.
// Both channels move a word at a rising edge with valid and ready high.
// From request accept to response valid a word passes an input register,
// then shifter and ALU logic into the output register.
// Throughput is one word per cycle while rsp_bus does not stall; the shifter
// and the 32-bit adder are the combinational path between the two registers.
// When rsp_bus stalls, the output register holds its word and the input
// register holds one more; req_bus.ready drops only when both are full.
// Synchronous reset empties both registers; no words are in flight after it.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_top (
   input  logic               clock,
   input  logic               reset,
   adp_alu_req_if.sink        req_bus,
   adp_alu_rsp_if.source      rsp_bus
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   adp_alu_pkg::req_type         s1_req_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   adp_alu_pkg::rsp_type         out_rsp_ff;
   adp_alu_pkg::shifter_out_type shift;
   adp_alu_pkg::rsp_type         alu_rsp;
   logic                         s1_adv;
   logic                         req_take;

   assign s1_adv       = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = ~s1_valid_ff | s1_adv;
   assign req_take     = req_bus.valid & req_bus.ready;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_adv);
   assign out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_bus.payload;
      end
      if (s1_adv && s1_valid_ff) begin
         out_rsp_ff <= alu_rsp;
      end
   end

   adp_alu_shifter u_shifter (
      .req   (s1_req_ff),
      .shift (shift)
   );

   adp_alu_core u_core (
      .req   (s1_req_ff),
      .shift (shift),
      .rsp   (alu_rsp)
   );

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_rsp_ff;

endmodule

@@ src/adp_alu_shifter.sv @@
// ----------------------------------------------------------------------------
// adp_alu_shifter
// Second-operand barrel shifter with shifter carry-out.
// ----------------------------------------------------------------------------
module adp_alu_shifter (
   input  adp_alu_pkg::req_type         req,
   output adp_alu_pkg::shifter_out_type shift
);

   function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} >> n;
      return d[31:0];
   endfunction

   logic        old_c;
   logic [31:0] rm;
   logic [7:0]  amt;
   logic [4:0]  amt_lo;
   logic        amt_big;
   logic        amt_word;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [31:0] ror_val;
   logic [31:0] imm_val;
   adp_alu_pkg::shifter_out_type barrel;

   assign old_c = req.flags_in[1];
   assign rm    = req.second_operand;

   // immediate LSR/ASR by zero encode a shift by a full word
   always_comb begin
      if (req.operand_form == adp_alu_pkg::FORM_IMM_SHIFT) begin
         amt = (req.shift_count[4:0] == 5'd0) ? adp_alu_pkg::SHIFT_WORD
                                              : {3'b000, req.shift_count[4:0]};
      end else begin
         amt = req.shift_count;
      end
   end

   assign amt_lo   = amt[4:0];
   assign amt_big  = |amt[7:5];
   assign amt_word = (amt == adp_alu_pkg::SHIFT_WORD);
   assign lsl_wide = {1'b0, rm} << amt_lo;
   assign lsr_wide = {rm, 1'b0} >> amt_lo;
   assign asr_wide = 33'($signed({rm, 1'b0}) >>> amt_lo);
   assign ror_val  = rotr(rm, amt_lo);
   assign imm_val  = rotr({24'd0, req.imm_byte}, {req.rotate_field, 1'b0});

   always_comb begin
      case (req.shift_kind)
         adp_alu_pkg::KIND_LSL: begin
            if (amt_big) begin
               barrel = '{operand: 32'd0, carry: amt_word & rm[0]};
            end else begin
               barrel = '{operand: lsl_wide[31:0], carry: lsl_wide[32]};
            end
         end
         adp_alu_pkg::KIND_LSR: begin
            if (amt_big) begin
               barrel = '{operand: 32'd0, carry: amt_word & rm[31]};
            end else begin
               barrel = '{operand: lsr_wide[32:1], carry: lsr_wide[0]};
            end
         end
         adp_alu_pkg::KIND_ASR: begin
            if (amt_big) begin
               barrel = '{operand: {32{rm[31]}}, carry: rm[31]};
            end else begin
               barrel = '{operand: asr_wide[32:1], carry: asr_wide[0]};
            end
         end
         default: begin
            barrel = '{operand: ror_val, carry: ror_val[31]};
         end
      endcase
   end

   always_comb begin
      if (req.operand_form == adp_alu_pkg::FORM_ROT_IMM) begin
         shift.operand = imm_val;
         shift.carry   = (req.rotate_field != 4'd0) ? imm_val[31] : old_c;
      end else if (req.operand_form == adp_alu_pkg::FORM_IMM_SHIFT &&
                   req.shift_count[4:0] == 5'd0 &&
                   req.shift_kind == adp_alu_pkg::KIND_LSL) begin
         shift.operand = rm;
         shift.carry   = old_c;
      end else if (req.operand_form == adp_alu_pkg::FORM_IMM_SHIFT &&
                   req.shift_count[4:0] == 5'd0 &&
                   req.shift_kind == adp_alu_pkg::KIND_ROR) begin
         // RRX
         shift.operand = {old_c, rm[31:1]};
         shift.carry   = rm[0];
      end else if (req.operand_form != adp_alu_pkg::FORM_IMM_SHIFT &&
                   req.operand_form != adp_alu_pkg::FORM_ROT_IMM &&
                   req.shift_count == 8'd0) begin
         shift.operand = rm;
         shift.carry   = old_c;
      end else begin
         shift = barrel;
      end
   end

endmodule

@@ src/adp_alu_core.sv @@
// ----------------------------------------------------------------------------
// adp_alu_core
// Opcode decode, shared adder, logic ops and NZCV generation.
// ----------------------------------------------------------------------------
module adp_alu_core (
   input  adp_alu_pkg::req_type         req,
   input  adp_alu_pkg::shifter_out_type shift,
   output adp_alu_pkg::rsp_type         rsp
);

   adp_alu_pkg::op_type op;
   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        add_cin;
   logic [32:0] sum;
   logic [31:0] res;
   logic        arith;
   logic        compare;
   logic        flag_wr;
   logic        c_new;
   logic        v_new;
   logic        old_c;

   assign op    = adp_alu_pkg::op_type'(req.op);
   assign a     = req.first_operand;
   assign b     = shift.operand;
   assign old_c = req.flags_in[1];

   always_comb begin
      case (op)
         adp_alu_pkg::OP_SUB, adp_alu_pkg::OP_CMP: begin
            add_x = a;  add_y = ~b; add_cin = 1'b1;
         end
         adp_alu_pkg::OP_RSB: begin
            add_x = b;  add_y = ~a; add_cin = 1'b1;
         end
         adp_alu_pkg::OP_ADC: begin
            add_x = a;  add_y = b;  add_cin = old_c;
         end
         adp_alu_pkg::OP_SBC: begin
            add_x = a;  add_y = ~b; add_cin = old_c;
         end
         adp_alu_pkg::OP_RSC: begin
            add_x = b;  add_y = ~a; add_cin = old_c;
         end
         default: begin
            add_x = a;  add_y = b;  add_cin = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};

   always_comb begin
      case (op)
         adp_alu_pkg::OP_AND, adp_alu_pkg::OP_TST: res = a & b;
         adp_alu_pkg::OP_EOR, adp_alu_pkg::OP_TEQ: res = a ^ b;
         adp_alu_pkg::OP_ORR:                      res = a | b;
         adp_alu_pkg::OP_MOV:                      res = b;
         adp_alu_pkg::OP_BIC:                      res = a & ~b;
         adp_alu_pkg::OP_MVN:                      res = ~b;
         default:                                  res = sum[31:0];
      endcase
   end

   assign arith   = op inside {adp_alu_pkg::OP_SUB, adp_alu_pkg::OP_RSB, adp_alu_pkg::OP_ADD,
                               adp_alu_pkg::OP_ADC, adp_alu_pkg::OP_SBC, adp_alu_pkg::OP_RSC,
                               adp_alu_pkg::OP_CMP, adp_alu_pkg::OP_CMN};
   assign compare = op inside {adp_alu_pkg::OP_TST, adp_alu_pkg::OP_TEQ,
                               adp_alu_pkg::OP_CMP, adp_alu_pkg::OP_CMN};
   assign flag_wr = compare | req.set_flags;
   assign c_new   = arith ? sum[32] : shift.carry;
   assign v_new   = arith ? (~(add_x[31] ^ add_y[31]) & (add_x[31] ^ res[31]))
                          : req.flags_in[0];

   always_comb begin
      rsp.alu_result    = res;
      rsp.write_enable  = ~compare;
      rsp.flags_written = flag_wr;
      rsp.flags_out     = flag_wr ? {res[31], (res == 32'd0), c_new, v_new} : req.flags_in;
   end

endmodule

@@ src/adp_alu_checker.sv @@
// ----------------------------------------------------------------------------
// adp_alu_checker
// Port-level checks on the data-processing ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm_data_processing_alu_top_defines.svh"

module adp_alu_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input adp_alu_pkg::rsp_type rsp_payload
);

   `ADP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `ADP_ASSERT_IMP(a_cmp_flags, clock, reset, rsp_valid && !rsp_payload.write_enable, rsp_payload.flags_written)
   `ADP_ASSERT_IMP(a_nz_flags, clock, reset, rsp_valid && rsp_payload.flags_written, (rsp_payload.flags_out[3] == rsp_payload.alu_result[31]) && (rsp_payload.flags_out[2] == (rsp_payload.alu_result == 32'd0)))
   `ADP_ASSERT_NXT(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready, rsp_valid)

endmodule

bind arm_data_processing_alu_top adp_alu_checker u_adp_alu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
